// ----- hdl/vdrh_pkg.sv -----
// Package for the rate-1/2 soft-decision Viterbi decoder.
// Holds widths, the parity helper, the decision record and the metric saturation.
// No dependencies.
package vdrh_pkg;

    localparam int MAX_MEMORY  = 6;
    localparam int NUM_STATES  = 1 << MAX_MEMORY;
    localparam int MAX_FRAME   = 256;
    localparam int FRAME_BITS  = $clog2(MAX_FRAME);
    localparam int WORD_BITS   = 16;
    localparam int CNT_BITS    = $clog2(WORD_BITS + 1);
    localparam int LLR_BITS    = 8;
    localparam int METRIC_BITS = 24;
    localparam int GEN_BITS    = 7;
    localparam int MEM_BITS    = 3;
    localparam int STATE_BITS  = MAX_MEMORY;

    localparam logic [METRIC_BITS-1:0] START_METRIC = METRIC_BITS'(65536);

    // configuration register indexes
    localparam logic [0:0] REG_GEN_ONE = 1'b0;
    localparam logic [0:0] REG_GEN_TWO = 1'b1;

    typedef logic signed [METRIC_BITS-1:0] metric_t;
    typedef logic [NUM_STATES-1:0]         decision_t;

    // per-step branch inputs shared by every lane
    typedef struct packed {
        logic [GEN_BITS-1:0]        gen_one;
        logic [GEN_BITS-1:0]        gen_two;
        logic [MEM_BITS-1:0]        mem_len;
        logic signed [LLR_BITS-1:0] llr_first;
        logic signed [LLR_BITS-1:0] llr_second;
    } branch_ctl_t;

    function automatic logic parity7(input logic [GEN_BITS-1:0] v);
        return ^v;
    endfunction

    function automatic metric_t sat_add(input metric_t a, input logic signed [LLR_BITS:0] b);
        logic signed [METRIC_BITS:0] s;
        s = {a[METRIC_BITS-1], a} + (METRIC_BITS+1)'(b);
        if (s[METRIC_BITS] != s[METRIC_BITS-1])
            return s[METRIC_BITS] ? {1'b1, {(METRIC_BITS-1){1'b0}}}
                                  : {1'b0, {(METRIC_BITS-1){1'b1}}};
        return s[METRIC_BITS-1:0];
    endfunction

endpackage

// ----- hdl/vdrh_acs_lane.sv -----
// One add-compare-select lane: computes the survivor for one next state.
// Depends on vdrh_pkg.
module vdrh_acs_lane (
    input  vdrh_pkg::branch_ctl_t                      ctl,
    input  logic [vdrh_pkg::STATE_BITS-1:0]            nxt,
    input  vdrh_pkg::metric_t                          pm_even,
    input  vdrh_pkg::metric_t                          pm_odd,
    output vdrh_pkg::metric_t                          pm_out,
    output logic                                       dec_out
);
    import vdrh_pkg::*;

    logic [GEN_BITS-1:0]         s_even;
    logic [GEN_BITS-1:0]         s_odd;
    logic                        in_bit;
    logic signed [LLR_BITS:0]    bm_even;
    logic signed [LLR_BITS:0]    bm_odd;
    metric_t                     cand_even;
    metric_t                     cand_odd;
    logic [STATE_BITS-1:0]       pred;

    // predecessor pair and decoded input bit for this next state
    always_comb begin
        in_bit = nxt[ctl.mem_len - 3'd1];
        pred   = (nxt << 1) & ((STATE_BITS'(1) << ctl.mem_len) - STATE_BITS'(1));
        s_even = GEN_BITS'({pred[STATE_BITS-1:1], 1'b0}) | (GEN_BITS'(in_bit) << ctl.mem_len);
        s_odd  = s_even | GEN_BITS'(1);
    end

    // branch metrics: LLRs where the expected code bit is one
    always_comb begin
        bm_even = '0;
        bm_odd  = '0;
        if (parity7(ctl.gen_one & s_even)) bm_even = bm_even + ctl.llr_first;
        if (parity7(ctl.gen_two & s_even)) bm_even = bm_even + ctl.llr_second;
        if (parity7(ctl.gen_one & s_odd))  bm_odd  = bm_odd + ctl.llr_first;
        if (parity7(ctl.gen_two & s_odd))  bm_odd  = bm_odd + ctl.llr_second;
        cand_even = sat_add(pm_even, bm_even);
        cand_odd  = sat_add(pm_odd, bm_odd);
    end

    // keep the larger, ties to the odd state
    assign dec_out = !(cand_even > cand_odd);
    assign pm_out  = dec_out ? cand_odd : cand_even;

endmodule

// ----- hdl/vdrh_traceback.sv -----
// Traceback and word packing: walks the survivor memory back from the best state.
// Depends on vdrh_pkg.
module vdrh_traceback (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [vdrh_pkg::STATE_BITS-1:0]     start_state,
    input  logic [vdrh_pkg::FRAME_BITS:0]       frame_len,
    input  logic [vdrh_pkg::MEM_BITS-1:0]       mem_len,
    input  logic                                drop,
    input  logic                                dec_we,
    input  logic [vdrh_pkg::FRAME_BITS-1:0]     dec_waddr,
    input  vdrh_pkg::decision_t                 dec_wdata,
    output logic                                busy,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [vdrh_pkg::WORD_BITS-1:0]      m_bits_word,
    output logic [vdrh_pkg::CNT_BITS-1:0]       m_bit_count,
    output logic                                m_last_word,
    output logic                                m_overflow
);
    import vdrh_pkg::*;

    typedef enum logic [3:0] {
        TB_IDLE = 4'b0001,
        TB_READ = 4'b0010,
        TB_WALK = 4'b0100,
        TB_EMIT = 4'b1000
    } tb_state_t;

    decision_t             surv_mem [MAX_FRAME];
    logic                  bit_mem  [MAX_FRAME];
    decision_t             rd_data;
    logic                  bit_rd;

    tb_state_t             st_reg, st_next;
    logic [STATE_BITS-1:0] state_reg;
    logic [FRAME_BITS:0]   idx_reg;
    logic [FRAME_BITS:0]   len_reg;
    logic [FRAME_BITS:0]   pos_reg;
    logic [CNT_BITS-1:0]   fill_reg;
    logic [MEM_BITS-1:0]   mem_reg;
    logic                  drop_reg;
    logic [WORD_BITS-1:0]  word_reg;
    logic                  ovalid_reg;
    logic [WORD_BITS-1:0]  oword_reg;
    logic [CNT_BITS-1:0]   ocnt_reg;
    logic                  olast_reg;
    logic                  oovf_reg;
    logic                  out_free;
    logic                  emit_word;

    // survivor memory: one write port from the ACS, one read port here
    always_ff @(posedge aclk) begin
        if (dec_we) surv_mem[dec_waddr] <= dec_wdata;
        rd_data <= surv_mem[idx_reg[FRAME_BITS-1:0] - FRAME_BITS'(1)];
    end

    // decoded bit buffer
    always_ff @(posedge aclk) begin
        if (st_reg == TB_WALK)
            bit_mem[idx_reg[FRAME_BITS-1:0] - FRAME_BITS'(1)] <= state_reg[mem_reg - 3'd1];
        bit_rd <= bit_mem[pos_reg[FRAME_BITS-1:0]];
    end

    assign out_free  = !ovalid_reg || m_ready;
    assign busy      = (st_reg != TB_IDLE) || ovalid_reg;
    assign emit_word = (st_reg == TB_EMIT) && (fill_reg != '0) &&
                       (fill_reg == CNT_BITS'(WORD_BITS) || pos_reg == len_reg) && out_free;

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            TB_IDLE: if (start) st_next = (frame_len == '0) ? TB_IDLE : TB_READ;
            TB_READ: st_next = TB_WALK;
            TB_WALK: st_next = (idx_reg == (FRAME_BITS+1)'(1)) ? TB_EMIT : TB_READ;
            TB_EMIT: if (pos_reg == len_reg && out_free) st_next = TB_IDLE;
            default: st_next = TB_IDLE;
        endcase
    end

    // emit phase alternates a fetch step and a pack step per bit; the bit buffer read is registered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= TB_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (emit_word) ovalid_reg <= 1'b1;
            else if (m_ready) ovalid_reg <= 1'b0;
            case (st_reg)
                TB_IDLE: begin
                    state_reg <= start_state;
                    idx_reg   <= frame_len;
                    len_reg   <= frame_len;
                    mem_reg   <= mem_len;
                    drop_reg  <= drop;
                    pos_reg   <= '0;
                    fill_reg  <= '0;
                    word_reg  <= '0;
                end
                TB_WALK: begin
                    state_reg <= ((state_reg << 1) &
                                  ((STATE_BITS'(1) << mem_reg) - STATE_BITS'(1))) |
                                 STATE_BITS'(rd_data[state_reg]);
                    idx_reg   <= idx_reg - (FRAME_BITS+1)'(1);
                end
                TB_EMIT: begin
                    if (fill_reg != '0 && (fill_reg == CNT_BITS'(WORD_BITS) ||
                                           pos_reg == len_reg)) begin
                        // hand a packed word to the output register
                        if (out_free) begin
                            oword_reg  <= word_reg;
                            ocnt_reg   <= fill_reg;
                            olast_reg  <= (pos_reg == len_reg);
                            oovf_reg   <= drop_reg;
                            fill_reg   <= '0;
                            word_reg   <= '0;
                        end
                    end else if (pos_reg != len_reg) begin
                        // idx_reg doubles as a fetch-phase flag via idx_reg[0]
                        if (idx_reg[0]) begin
                            word_reg <= word_reg | (WORD_BITS'(bit_rd) << fill_reg);
                            fill_reg <= fill_reg + CNT_BITS'(1);
                            pos_reg  <= pos_reg + (FRAME_BITS+1)'(1);
                            idx_reg  <= '0;
                        end else begin
                            idx_reg  <= (FRAME_BITS+1)'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid     = ovalid_reg;
    assign m_bits_word = oword_reg;
    assign m_bit_count = ocnt_reg;
    assign m_last_word = olast_reg;
    assign m_overflow  = oovf_reg;

    // a word never carries more bits than a word holds
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_bit_count != '0 && m_bit_count <= CNT_BITS'(WORD_BITS)))
        else $error("bit count out of range");
    // a pending word holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_bits_word))
        else $error("output changed while stalled");
    // walk never underruns the frame
    a_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == TB_WALK |-> idx_reg != '0)
        else $error("traceback index underrun");

endmodule

// ----- hdl/viterbi_decoder_rate_half.sv -----
// Rate-1/2 soft-decision Viterbi decoder, top level: metric lanes, best-state merge
// and traceback. After the frame-end beat the block scans for the best state, traces
// back through the survivors (a read and a walk step per traced step), packs the bits
// (a fetch and a pack step per bit) and moves each word into the output register.
// Throughput: one pair per cycle during a frame, set by the 64 parallel ACS lanes;
// input waits from frame end until the last word is taken. Reset (aresetn, synchronous):
// metrics to start values, counters and flags cleared, generators to 91 and 121.
// Depends on vdrh_pkg, vdrh_acs_lane, vdrh_traceback.
module viterbi_decoder_rate_half (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      cfg_we,
    input  logic [0:0]                                cfg_index,
    input  logic [vdrh_pkg::GEN_BITS-1:0]             cfg_data,
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic signed [vdrh_pkg::LLR_BITS-1:0]      s_llr_first,
    input  logic signed [vdrh_pkg::LLR_BITS-1:0]      s_llr_second,
    input  logic                                      s_frame_end,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic [vdrh_pkg::WORD_BITS-1:0]            m_bits_word,
    output logic [vdrh_pkg::CNT_BITS-1:0]             m_bit_count,
    output logic                                      m_last_word,
    output logic                                      m_overflow
);
    import vdrh_pkg::*;

    typedef enum logic [2:0] {
        ST_RUN  = 3'b001,
        ST_SCAN = 3'b010,
        ST_TB   = 3'b100
    } top_state_t;

    logic [GEN_BITS-1:0]    gen_one_reg, gen_two_reg;
    metric_t                pm_reg [NUM_STATES];
    metric_t                pm_new [NUM_STATES];
    decision_t              dec_new;
    logic [FRAME_BITS:0]    step_reg;
    logic                   drop_reg;
    top_state_t             st_reg;
    logic [STATE_BITS:0]    scan_reg;
    logic [STATE_BITS-1:0]  best_reg;
    metric_t                best_m_reg;
    logic [MEM_BITS-1:0]    mem_len;
    logic [GEN_BITS-1:0]    g_or;
    branch_ctl_t            ctl;
    logic                   accept, do_acs, tb_busy, tb_start;

    // code memory from the highest generator bit
    always_comb begin
        g_or    = gen_one_reg | gen_two_reg;
        mem_len = 3'd1;
        for (int i = 2; i < GEN_BITS; i++)
            if (g_or[i]) mem_len = MEM_BITS'(i);
        if (mem_len > MEM_BITS'(MAX_MEMORY)) mem_len = MEM_BITS'(MAX_MEMORY);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_one_reg <= GEN_BITS'(91);
            gen_two_reg <= GEN_BITS'(121);
        end else if (cfg_we) begin
            if (cfg_index == REG_GEN_ONE) gen_one_reg <= cfg_data;
            if (cfg_index == REG_GEN_TWO) gen_two_reg <= cfg_data;
        end
    end

    assign ctl = '{gen_one: gen_one_reg, gen_two: gen_two_reg, mem_len: mem_len,
                   llr_first: s_llr_first, llr_second: s_llr_second};

    // parallel ACS lanes, one per next state
    for (genvar n = 0; n < NUM_STATES; n++) begin : g_lane
        metric_t pe, po;
        logic [STATE_BITS-1:0] pidx;
        always_comb begin
            pidx = STATE_BITS'(n << 1) & ((STATE_BITS'(1) << mem_len) - STATE_BITS'(1));
            pe   = pm_reg[{pidx[STATE_BITS-1:1], 1'b0}];
            po   = pm_reg[{pidx[STATE_BITS-1:1], 1'b1}];
        end
        vdrh_acs_lane u_lane (
            .ctl(ctl), .nxt(STATE_BITS'(n)), .pm_even(pe), .pm_odd(po),
            .pm_out(pm_new[n]), .dec_out(dec_new[n])
        );
    end

    assign s_ready  = (st_reg == ST_RUN) && !tb_busy;
    assign accept   = s_valid && s_ready;
    assign do_acs   = accept && (step_reg < (FRAME_BITS+1)'(MAX_FRAME));
    assign tb_start = (st_reg == ST_SCAN) && (scan_reg == (STATE_BITS+1)'(NUM_STATES));

    // frame control, metrics and best-state merge across the lanes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_RUN;
            step_reg <= '0;
            drop_reg <= 1'b0;
            for (int i = 0; i < NUM_STATES; i++)
                pm_reg[i] <= (i == 0) ? START_METRIC : '0;
        end else begin
            case (st_reg)
                ST_RUN: if (accept) begin
                    if (do_acs) begin
                        for (int i = 0; i < NUM_STATES; i++)
                            if (i < (1 << mem_len)) pm_reg[i] <= pm_new[i];
                            else pm_reg[i] <= '0;
                        step_reg <= step_reg + (FRAME_BITS+1)'(1);
                    end else begin
                        drop_reg <= 1'b1;
                    end
                    if (s_frame_end) begin
                        st_reg     <= ST_SCAN;
                        scan_reg   <= '0;
                        best_reg   <= '0;
                        best_m_reg <= '0;
                    end
                end
                ST_SCAN: begin
                    if (scan_reg == (STATE_BITS+1)'(NUM_STATES)) begin
                        st_reg   <= ST_RUN;
                        step_reg <= '0;
                        drop_reg <= 1'b0;
                        for (int i = 0; i < NUM_STATES; i++)
                            pm_reg[i] <= (i == 0) ? START_METRIC : '0;
                    end else begin
                        if (scan_reg < ((STATE_BITS+1)'(1) << mem_len) &&
                            pm_reg[scan_reg[STATE_BITS-1:0]] > best_m_reg) begin
                            best_m_reg <= pm_reg[scan_reg[STATE_BITS-1:0]];
                            best_reg   <= scan_reg[STATE_BITS-1:0];
                        end
                        scan_reg <= scan_reg + (STATE_BITS+1)'(1);
                    end
                end
                default: st_reg <= ST_RUN;
            endcase
        end
    end

    vdrh_traceback u_tb (
        .aclk(aclk), .aresetn(aresetn), .start(tb_start), .start_state(best_reg),
        .frame_len(step_reg), .mem_len(mem_len), .drop(drop_reg),
        .dec_we(do_acs), .dec_waddr(step_reg[FRAME_BITS-1:0]), .dec_wdata(dec_new),
        .busy(tb_busy), .m_valid(m_valid), .m_ready(m_ready),
        .m_bits_word(m_bits_word), .m_bit_count(m_bit_count),
        .m_last_word(m_last_word), .m_overflow(m_overflow)
    );

    // no pair is taken during the frame-end scan
    a_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_SCAN |-> !s_ready) else $error("input taken during scan");
    // the step counter never passes the frame limit
    a_step: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= (FRAME_BITS+1)'(MAX_FRAME)) else $error("step count overrun");
    // a frame end always leads into the scan
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_frame_end |=> st_reg == ST_SCAN) else $error("frame end lost");

endmodule

// ----- bench/tb_viterbi_decoder_rate_half.sv -----
// Self-checking testbench for the rate-1/2 soft-decision Viterbi decoder.
// Carries its own trellis predictor and compares every decoded word with it.
// Depends on vdrh_pkg and viterbi_decoder_rate_half.
`timescale 1ns / 1ps

module tb_viterbi_decoder_rate_half;
    import vdrh_pkg::*;

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  SETTLE      = 80;
    localparam longint MET_HI   = (64'sd1 <<< (METRIC_BITS - 1)) - 1;
    localparam longint MET_LO   = -MET_HI - 1;

    typedef struct {
        logic [WORD_BITS-1:0] bits_word;
        logic [CNT_BITS-1:0]  bit_count;
        logic                 last_word;
        logic                 overflow;
    } decoded_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_index = REG_GEN_ONE;
    logic [GEN_BITS-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [LLR_BITS-1:0] s_llr_first = '0;
    logic signed [LLR_BITS-1:0] s_llr_second = '0;
    logic s_frame_end = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [WORD_BITS-1:0] m_bits_word;
    logic [CNT_BITS-1:0] m_bit_count;
    logic m_last_word;
    logic m_overflow;

    viterbi_decoder_rate_half uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_llr_first(s_llr_first), .s_llr_second(s_llr_second),
        .s_frame_end(s_frame_end),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_bits_word(m_bits_word), .m_bit_count(m_bit_count),
        .m_last_word(m_last_word), .m_overflow(m_overflow)
    );

    always #1 aclk = ~aclk;

    // predictor state
    logic [GEN_BITS-1:0] pr_gen_one = 7'd91;
    logic [GEN_BITS-1:0] pr_gen_two = 7'd121;
    longint              pr_metric [NUM_STATES];
    logic [NUM_STATES-1:0] pr_survivor [MAX_FRAME];
    logic                pr_bits [MAX_FRAME];
    int                  pr_steps = 0;
    bit                  pr_dropped = 0;

    decoded_word_t expected_words [$];
    int  fail_count = 0;
    int  words_checked = 0;
    int  frames_sent = 0;
    int  pairs_sent = 0;
    int  cycles = 0;
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;

    function automatic int code_memory();
        logic [GEN_BITS-1:0] g;
        int m;
        g = pr_gen_one | pr_gen_two;
        m = 0;
        for (int i = 0; i < GEN_BITS; i++)
            if (g[i]) m = i;
        if (m < 1) m = 1;
        if (m > MAX_MEMORY) m = MAX_MEMORY;
        return m;
    endfunction

    function automatic longint clip_metric(input longint v);
        if (v > MET_HI) return MET_HI;
        if (v < MET_LO) return MET_LO;
        return v;
    endfunction

    task automatic clear_metrics();
        foreach (pr_metric[i]) pr_metric[i] = 0;
        pr_metric[0] = 65536;
    endtask

    // one add-compare-select step across the trellis
    task automatic trellis_step(input longint l1, input longint l2);
        int m, ns, nxt;
        longint nmet [NUM_STATES];
        longint cand [2];
        logic [NUM_STATES-1:0] dec;
        logic [GEN_BITS-1:0] s;
        longint bm;
        m = code_memory();
        ns = 1 << m;
        dec = '0;
        foreach (nmet[i]) nmet[i] = 0;
        for (int j = 0; j < ns; j += 2) begin
            for (int b = 0; b < 2; b++) begin
                nxt = (j >> 1) + b * (1 << (m - 1));
                for (int k = 0; k < 2; k++) begin
                    s = GEN_BITS'(j + k) | (b ? GEN_BITS'(1 << m) : '0);
                    bm = 0;
                    if (^(pr_gen_one & s)) bm += l1;
                    if (^(pr_gen_two & s)) bm += l2;
                    cand[k] = clip_metric(pr_metric[j + k] + bm);
                end
                if (cand[0] > cand[1]) begin
                    nmet[nxt] = cand[0];
                end else begin
                    nmet[nxt] = cand[1];
                    dec[nxt] = 1'b1;
                end
            end
        end
        foreach (pr_metric[i]) pr_metric[i] = nmet[i];
        pr_survivor[pr_steps] = dec;
    endtask

    // expected words for one accepted pair
    task automatic predict_pair(input logic signed [LLR_BITS-1:0] a,
                                input logic signed [LLR_BITS-1:0] b, input bit fe);
        int m, ns, st, fl, n;
        longint best;
        decoded_word_t w;
        if (pr_steps < MAX_FRAME) begin
            trellis_step(longint'(a), longint'(b));
            pr_steps++;
        end else begin
            pr_dropped = 1;
        end
        if (!fe) return;
        m = code_memory();
        ns = 1 << m;
        st = 0;
        best = 0;
        for (int i = 0; i < ns; i++)
            if (pr_metric[i] > best) begin
                best = pr_metric[i];
                st = i;
            end
        fl = pr_steps;
        for (int i = fl; i >= 1; i--) begin
            pr_bits[i - 1] = (st >> (m - 1)) & 1;
            st = ((st << 1) & (ns - 1)) | int'(pr_survivor[i - 1][st]);
        end
        for (int pos = 0; pos < fl; pos += WORD_BITS) begin
            n = (fl - pos > WORD_BITS) ? WORD_BITS : fl - pos;
            w.bits_word = '0;
            for (int i = 0; i < n; i++) w.bits_word[i] = pr_bits[pos + i];
            w.bit_count = CNT_BITS'(n);
            w.last_word = (pos + n >= fl);
            w.overflow = pr_dropped;
            expected_words.push_back(w);
        end
        clear_metrics();
        pr_steps = 0;
        pr_dropped = 0;
    endtask

    // drive one beat and wait for it to be taken
    task automatic send_pair(input logic signed [LLR_BITS-1:0] a,
                             input logic signed [LLR_BITS-1:0] b, input bit fe);
        s_valid <= 1'b1;
        s_llr_first <= a;
        s_llr_second <= b;
        s_frame_end <= fe;
        do @(posedge aclk); while (!s_ready);
        predict_pair(a, b, fe);
        pairs_sent++;
        if (fe) frames_sent++;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    // wait for all outstanding words, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_gens(input logic [GEN_BITS-1:0] g1, input logic [GEN_BITS-1:0] g2);
        cfg_we <= 1'b1;
        cfg_index <= REG_GEN_ONE;
        cfg_data <= g1;
        @(posedge aclk);
        pr_gen_one = g1;
        cfg_index <= REG_GEN_TWO;
        cfg_data <= g2;
        @(posedge aclk);
        pr_gen_two = g2;
        cfg_we <= 1'b0;
    endtask

    // frame of encoded random bits with noisy soft values
    task automatic send_coded_frame(input int len, input int amp, input int noise);
        int m, st, v1, v2;
        logic [GEN_BITS-1:0] r;
        m = code_memory();
        st = 0;
        for (int i = 0; i < len; i++) begin
            r = GEN_BITS'(st) | ($urandom_range(1) ? GEN_BITS'(1 << m) : '0);
            v1 = (^(pr_gen_one & r) ? amp : -amp) + $urandom_range(2 * noise) - noise;
            v2 = (^(pr_gen_two & r) ? amp : -amp) + $urandom_range(2 * noise) - noise;
            if (v1 > 127) v1 = 127;
            if (v1 < -128) v1 = -128;
            if (v2 > 127) v2 = 127;
            if (v2 < -128) v2 = -128;
            st = int'(r) >> 1;
            send_pair(LLR_BITS'(v1), LLR_BITS'(v2), i == len - 1);
        end
    endtask

    task automatic send_noise_frame(input int len);
        for (int i = 0; i < len; i++)
            send_pair(LLR_BITS'($urandom), LLR_BITS'($urandom), i == len - 1);
    endtask

    // extremes, ties and word boundaries at reset generators, then all-zero and all-one generators
    task automatic test_directed();
        send_pair(8'sd127, 8'sd127, 1'b0);
        send_pair(-8'sd128, -8'sd128, 1'b0);
        send_pair(8'sd127, -8'sd128, 1'b0);
        send_pair(-8'sd128, 8'sd127, 1'b1);
        send_pair(8'sd0, 8'sd0, 1'b1);
        send_noise_frame(1);
        for (int i = 0; i < 16; i++) send_pair(8'sd0, 8'sd0, i == 15);
        drain();
        write_gens(7'd0, 7'd0);
        send_pair(8'sd5, -8'sd3, 1'b1);
        drain();
        write_gens(7'd127, 7'd127);
        send_coded_frame(17, 60, 20);
        drain();
    endtask

    // frame longer than the buffer; the dropped final pair still ends it
    task automatic test_overflow();
        write_gens(7'd7, 7'd5);
        send_coded_frame(MAX_FRAME + 2, 50, 40);
        drain();
    endtask

    // hold the sender until every word of the frame has come back
    task automatic test_pause();
        send_coded_frame(20, 40, 30);
        drain();
        send_noise_frame(9);
        drain();
    endtask

    task automatic test_random_phase(input int idle, input int stall, input int pairs);
        int sent;
        tx_idle_pct = idle;
        rx_stall_pct = stall;
        write_gens(GEN_BITS'($urandom), GEN_BITS'($urandom));
        sent = 0;
        while (sent < pairs) begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 30) : $urandom_range(24, 1);
            if ($urandom_range(3) == 0) send_noise_frame(len);
            else send_coded_frame(len, $urandom_range(100, 10), $urandom_range(60));
            sent += len;
        end
        drain();
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            decoded_word_t e;
            if (expected_words.size() == 0) begin
                $error("unexpected word: bits_word=%h", m_bits_word);
                fail_count++;
            end else begin
                e = expected_words.pop_front();
                words_checked++;
                if (m_bits_word !== e.bits_word) begin
                    $error("bits_word expected %h actual %h", e.bits_word, m_bits_word);
                    fail_count++;
                end
                if (m_bit_count !== e.bit_count) begin
                    $error("bit_count expected %0d actual %0d", e.bit_count, m_bit_count);
                    fail_count++;
                end
                if (m_last_word !== e.last_word) begin
                    $error("last_word expected %b actual %b", e.last_word, m_last_word);
                    fail_count++;
                end
                if (m_overflow !== e.overflow) begin
                    $error("overflow expected %b actual %b", e.overflow, m_overflow);
                    fail_count++;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        clear_metrics();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_overflow();
        test_pause();
        test_random_phase(0, 0, 55);
        test_random_phase(47, 0, 55);
        test_random_phase(0, 47, 55);
        test_random_phase(21, 21, 55);
        write_gens(7'd91, 7'd121);
        test_random_phase(0, 0, 10);
        if (expected_words.size() != 0) begin
            $error("%0d expected words never arrived", expected_words.size());
            fail_count++;
        end
        $display("Decoded %0d frames from %0d pairs, %0d words checked, %0d mismatches.",
                 frames_sent, pairs_sent, words_checked, fail_count);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
